// ===== src/ihex_pkg.sv =====
// Shared types and constants for the Intel HEX record decoder.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Events handed from the character front end to the record engine
    typedef enum logic [1:0] {
        EVT_START = 2'd0,
        EVT_ABORT = 2'd1,
        EVT_BYTE  = 2'd2
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t  kind;
        logic [7:0] data;
    } evt_t;

    // Hex digit value; anything that is not a letter digit maps to c - '0'
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CH_LC_A && c <= CH_LC_F)
            begin
                v = c - CH_LC_A + 8'd10;
            end
            else if (c >= CH_UC_A && c <= CH_UC_F)
            begin
                v = c - CH_UC_A + 8'd10;
            end
            else
            begin
                v = c - CH_ZERO;
            end
            return v;
        end
    endfunction

endpackage

// ===== src/ihex_front.sv =====
// Character front end: pairs hex digits into bytes and flags record delimiters.
`timescale 1ns / 1ps

module ihex_front
    import ihex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_char,
    input  logic       queue_full,
    output logic       push_valid,
    output evt_t       push_evt
);

    logic       pending_reg;
    logic       pending_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic [7:0] digit;
    logic       take;

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;
    assign digit    = digit_value(text_char);

    always_comb
    begin
        pending_next     = pending_reg;
        high_nibble_next = high_nibble_reg;
        push_valid       = 1'b0;
        push_evt.kind    = EVT_BYTE;
        push_evt.data    = {high_nibble_reg, 4'h0} + digit;
        if (take)
        begin
            if (text_char == CH_COLON)
            begin
                push_valid    = 1'b1;
                push_evt.kind = EVT_START;
                pending_next  = 1'b0;
            end
            else if (text_char == CH_CR)
            begin
                push_valid    = 1'b1;
                push_evt.kind = EVT_ABORT;
                pending_next  = 1'b0;
            end
            else if (text_char < CH_ZERO)
            begin
                // filler character, dropped
            end
            else if (!pending_reg)
            begin
                high_nibble_next = digit[3:0];
                pending_next     = 1'b1;
            end
            else
            begin
                push_valid   = 1'b1;
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b0;
            high_nibble_reg <= 4'h0;
        end
        else
        begin
            pending_reg     <= pending_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

endmodule

// ===== src/ihex_queue.sv =====
// Small event queue between the front end and the record engine.
`timescale 1ns / 1ps

module ihex_queue
    import ihex_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  evt_t push_evt,
    output logic full,
    input  logic pop,
    output logic empty,
    output evt_t pop_evt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    evt_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign pop_evt = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/ihex_engine.sv =====
// Record engine: walks the record fields, packs data words, checks the sum.
`timescale 1ns / 1ps

module ihex_engine
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        evt_valid,
    input  evt_t        evt,
    output logic        evt_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [31:0] word_address,
    output logic [31:0] word_data,
    output logic        checksum_bad,
    output logic        end_of_file
);

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HEAD = 6'b000010,
        PH_DATA = 6'b000100,
        PH_EXT  = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_SUM  = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hidx_reg, hidx_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  rkind_reg, rkind_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] upper_reg, upper_next;
    logic [7:0]  ext_reg, ext_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] offset_reg;
    logic [7:0]  wbytes_reg [4];

    logic        out_valid_reg;
    logic        kind_reg;
    logic [31:0] addr_reg;
    logic [31:0] data_reg;
    logic        bad_reg;
    logic        eof_reg;

    logic        res_valid;
    logic        res_kind;
    logic [31:0] res_addr;
    logic [31:0] res_data;
    logic        res_bad;
    logic        res_eof;

    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic [31:0] run_addr;
    logic [31:0] run_inc;
    logic        wb_write;

    assign evt_pop  = evt_valid && (!out_valid_reg || !out_stall);
    assign b        = evt.data;
    assign sum_add  = sum_reg + b;
    assign run_addr = {upper_reg, low_reg};
    assign run_inc  = run_addr + 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        left_next  = left_reg;
        rkind_next = rkind_reg;
        low_next   = low_reg;
        upper_next = upper_reg;
        ext_next   = ext_reg;
        sum_next   = sum_reg;
        wb_write   = 1'b0;
        res_valid  = 1'b0;
        res_kind   = KIND_WORD;
        res_addr   = '0;
        res_data   = '0;
        res_bad    = 1'b0;
        res_eof    = 1'b0;
        if (evt_pop)
        begin
            case (evt.kind)
                EVT_START:
                begin
                    phase_next = PH_HEAD;
                    hidx_next  = 2'd0;
                    sum_next   = 8'h00;
                end
                EVT_ABORT:
                begin
                    phase_next = PH_IDLE;
                end
                EVT_BYTE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        sum_next = sum_add;
                    end
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            // bytes outside a record are ignored
                        end
                        PH_HEAD:
                        begin
                            hidx_next = hidx_reg + 2'd1;
                            case (hidx_reg)
                                2'd0: left_next = b;
                                2'd1: low_next  = {b, 8'h00};
                                2'd2: low_next  = {low_reg[15:8], b};
                                default:
                                begin
                                    rkind_next = b;
                                    hidx_next  = 2'd0;
                                    if (b == REC_DATA)
                                    begin
                                        phase_next = (left_reg != 8'd0) ? PH_DATA : PH_SUM;
                                    end
                                    else if (b == REC_EXT)
                                    begin
                                        phase_next = PH_EXT;
                                    end
                                    else if (b == REC_EOF)
                                    begin
                                        phase_next = PH_SUM;
                                    end
                                    else
                                    begin
                                        phase_next = (left_reg != 8'd0) ? PH_SKIP : PH_SUM;
                                    end
                                end
                            endcase
                        end
                        PH_DATA:
                        begin
                            wb_write = 1'b1;
                            if (low_reg[1:0] == 2'd3)
                            begin
                                res_valid = 1'b1;
                                res_kind  = KIND_WORD;
                                res_addr  = {run_addr[31:2], 2'b00} + offset_reg;
                                // current byte bypasses the buffer into the top lane
                                res_data  = {b, wbytes_reg[2], wbytes_reg[1], wbytes_reg[0]};
                            end
                            low_next   = run_inc[15:0];
                            upper_next = run_inc[31:16];
                            left_next  = left_reg - 8'd1;
                            if (left_reg == 8'd1)
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_EXT:
                        begin
                            if (hidx_reg == 2'd0)
                            begin
                                ext_next  = b;
                                hidx_next = 2'd1;
                            end
                            else
                            begin
                                upper_next = {ext_reg, b};
                                hidx_next  = 2'd0;
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SKIP:
                        begin
                            left_next = left_reg - 8'd1;
                            if (left_reg == 8'd1)
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SUM:
                        begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_DONE;
                            res_bad    = (sum_add != 8'h00);
                            res_eof    = (rkind_reg == REC_EOF);
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_write)
        begin
            wbytes_reg[low_reg[1:0]] <= b;
        end
        if (evt_pop && res_valid)
        begin
            kind_reg <= res_kind;
            addr_reg <= res_addr;
            data_reg <= res_data;
            bad_reg  <= res_bad;
            eof_reg  <= res_eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hidx_reg      <= 2'd0;
            left_reg      <= 8'd0;
            rkind_reg     <= 8'd0;
            low_reg       <= 16'd0;
            upper_reg     <= 16'd0;
            ext_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            offset_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            left_reg  <= left_next;
            rkind_reg <= rkind_next;
            low_reg   <= low_next;
            upper_reg <= upper_next;
            ext_reg   <= ext_next;
            sum_reg   <= sum_next;
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            if (evt_pop && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign word_address = addr_reg;
    assign word_data    = data_reg;
    assign checksum_bad = bad_reg;
    assign end_of_file  = eof_reg;

endmodule

// ===== src/intel_hex_record_decoder.sv =====
// Top level of the Intel HEX record decoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_stall    | text_char
//  out      | out_valid / out_stall  | kind, word_address, word_data,
//           |                        | checksum_bad, end_of_file
//  cfg      | cfg_wr_en              | cfg_wr_data (target_offset)
//
// One character per cycle is taken while in_stall is low. Its event enters the queue
// at the edge that takes the character; the record engine pops one event per cycle
// unless out_stall holds back a result in the output register, and loads a result into
// that register at the edge that pops its event.
// Reset is asynchronous; no clearing pass is needed. in_stall rises only when the
// event queue is full, which happens only while out_stall holds a result back.
`timescale 1ns / 1ps

module intel_hex_record_decoder
    import ihex_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [31:0] word_address,
    output logic [31:0] word_data,
    output logic        checksum_bad,
    output logic        end_of_file
);

    logic q_full;
    logic q_empty;
    logic push_valid;
    evt_t push_evt;
    logic pop;
    evt_t pop_evt;

    ihex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_char  (text_char),
        .queue_full (q_full),
        .push_valid (push_valid),
        .push_evt   (push_evt)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_evt (push_evt),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_evt  (pop_evt)
    );

    ihex_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .evt_valid    (!q_empty),
        .evt          (pop_evt),
        .evt_pop      (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .word_address (word_address),
        .word_data    (word_data),
        .checksum_bad (checksum_bad),
        .end_of_file  (end_of_file)
    );

endmodule
